// ===== src/kmet_pkg.sv =====
`timescale 1ns / 1ps

package kmet_pkg;

	// Field widths of the ports.
	localparam int CMD_W      = 2;
	localparam int WORD_W     = 16;
	localparam int LOW_W      = 8;
	localparam int KIND_W     = 2;
	localparam int ROW_W      = 3;
	localparam int COL_W      = 3;
	localparam int CNT_W      = 7;
	localparam int ROWS_CFG_W = 4;
	localparam int TMO_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Default matrix size.
	localparam int MAX_ROWS_DEF = 8;
	localparam int MAX_COLS_DEF = 8;

	// Commands.
	localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ERROR = 2'd2;

	// Event kinds.
	localparam logic [KIND_W-1:0] EV_PRESS   = 2'd0;
	localparam logic [KIND_W-1:0] EV_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] EV_BADROW  = 2'd2;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0]  CFG_ROWS    = 1'd0;
	localparam logic [CFG_IDX_W-1:0]  CFG_TIMEOUT = 1'd1;
	localparam logic [ROWS_CFG_W-1:0] ROWS_RST    = 4'd8;
	localparam logic [TMO_W-1:0]      TMO_RST     = 16'd20;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [CNT_W-1:0]  count;
	} kmet_evt_t;

	typedef struct packed {
		logic push;
		logic fin;
	} kmet_buf_ctl_t;

	typedef struct packed {
		logic room;
		logic pend_v;
	} kmet_buf_sts_t;

endpackage

// ===== src/kmet_diff_unit.sv =====
`timescale 1ns / 1ps

module kmet_diff_unit #(
	parameter int MAX_COLS = kmet_pkg::MAX_COLS_DEF
) (
	input  logic [MAX_COLS-1:0]       old_cols,
	input  logic [MAX_COLS-1:0]       new_cols,
	input  logic [kmet_pkg::CNT_W-1:0] held,
	output logic                      found,
	output logic [kmet_pkg::COL_W-1:0] col,
	output logic                      press,
	output logic [MAX_COLS-1:0]       upd_cols,
	output logic [kmet_pkg::CNT_W-1:0] held_next
);
	import kmet_pkg::*;

	logic [MAX_COLS-1:0] diff;
	logic [MAX_COLS-1:0] low_bit;

	// The lowest differing column is handled first, so events come out in
	// ascending column order.
	assign diff    = old_cols ^ new_cols;
	assign low_bit = diff & (~diff + {{(MAX_COLS-1){1'b0}}, 1'b1});
	assign found   = |diff;
	assign press   = |(new_cols & low_bit);
	assign upd_cols = old_cols ^ low_bit;
	assign held_next = press ? held + {{(CNT_W-1){1'b0}}, 1'b1}
	                         : held - {{(CNT_W-1){1'b0}}, 1'b1};

	always_comb begin
		col = '0;
		for (int c = MAX_COLS - 1; c >= 0; c--) begin
			if (diff[c]) begin
				col = COL_W'(c);
			end
		end
	end

endmodule

// ===== src/kmet_evt_buf.sv =====
`timescale 1ns / 1ps

module kmet_evt_buf (
	input  logic                      clk,
	input  logic                      arst_n,
	input  kmet_pkg::kmet_buf_ctl_t   ctl,
	input  kmet_pkg::kmet_evt_t       evt,
	output kmet_pkg::kmet_buf_sts_t   sts,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [kmet_pkg::KIND_W-1:0] event_kind,
	output logic [kmet_pkg::ROW_W-1:0]  key_row,
	output logic [kmet_pkg::COL_W-1:0]  key_col,
	output logic [kmet_pkg::CNT_W-1:0]  pressed_count,
	output logic                      last_event
);
	import kmet_pkg::*;

	// One event is held back so that the last one of an item can be marked.
	logic      pend_v_q;
	kmet_evt_t pend_q;
	logic      out_v_q;
	kmet_evt_t out_q;
	logic      last_q;
	logic      out_free;
	logic      load_push;
	logic      load_fin;

	assign out_free  = !out_v_q || !out_stall;
	assign sts.room   = !pend_v_q || out_free;
	assign sts.pend_v = pend_v_q;
	assign load_push = ctl.push && pend_v_q && out_free;
	assign load_fin  = ctl.fin && pend_v_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (ctl.push && sts.room) begin
				pend_v_q <= 1'b1;
			end else if (load_fin) begin
				pend_v_q <= 1'b0;
			end
			if (load_push || load_fin) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push && sts.room) begin
			pend_q <= evt;
		end
		if (load_push || load_fin) begin
			out_q  <= pend_q;
			last_q <= load_fin;
		end
	end

	assign out_valid     = out_v_q;
	assign event_kind    = out_q.kind;
	assign key_row       = out_q.row;
	assign key_col       = out_q.col;
	assign pressed_count = out_q.count;
	assign last_event    = last_q;

endmodule

// ===== src/keypad_matrix_event_tracker_top.sv =====
`timescale 1ns / 1ps
// Output: a bad row result passes the hold-back stage and then the output register; a key
// event waits in the hold-back stage until the next event is found or the sweep ends.
// A new item is taken only in idle: the shared diff unit finds one key change at a time as
// the row sweep visits each row, and out stalls hold the sweep and the flush back.
// Reset (arst_n low): key map, held count, idle counter and last row clear at once,
// rows_in_use returns to 8 and release_timeout to 20.

module keypad_matrix_event_tracker_top #(
	parameter int MAX_ROWS = kmet_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = kmet_pkg::MAX_COLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [kmet_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kmet_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [kmet_pkg::CMD_W-1:0]      command,
	input  logic [kmet_pkg::WORD_W-1:0]     key_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [kmet_pkg::KIND_W-1:0]     event_kind,
	output logic [kmet_pkg::ROW_W-1:0]      key_row,
	output logic [kmet_pkg::COL_W-1:0]      key_col,
	output logic [kmet_pkg::CNT_W-1:0]      pressed_count,
	output logic                          last_event
);
	import kmet_pkg::*;

	localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAX_ROWS - 1);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	// Configuration registers.
	logic [ROWS_CFG_W-1:0] rows_q;
	logic [TMO_W-1:0]      timeout_q;

	// Tracker state. The key map is one row of column bits per matrix row.
	logic [MAX_COLS-1:0] map_q [MAX_ROWS];
	logic [ROW_W-1:0]    prev_q;
	logic [CNT_W-1:0]    held_q;
	logic [TMO_W-1:0]    idle_q;

	// Sweep control.
	logic [1:0]          state_q;
	logic [ROW_W-1:0]    cur_row_q;
	logic [ROW_W-1:0]    tgt_row_q;
	logic [MAX_COLS-1:0] tgt_cols_q;
	logic                rel_all_q;

	logic                accept;
	logic [ROWS_CFG_W-1:0] eff_rows;
	logic [LOW_W-1:0]    low;
	logic                one_hot;
	logic [ROW_W-1:0]    row_enc;
	logic                bad_row;
	logic [TMO_W-1:0]    tick_next;
	logic                tick_release;
	logic [ROW_W-1:0]    first_row;

	logic [MAX_COLS-1:0] old_cols;
	logic [MAX_COLS-1:0] new_cols;
	logic                d_found;
	logic [COL_W-1:0]    d_col;
	logic                d_press;
	logic [MAX_COLS-1:0] d_upd;
	logic [CNT_W-1:0]    d_held;
	logic                sweep_last;

	kmet_buf_ctl_t buf_ctl;
	kmet_buf_sts_t buf_sts;
	kmet_evt_t     evt;

	// Next row in scan order, wrapping at the effective row count.
	function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] r,
			input logic [ROWS_CFG_W-1:0] n);
		logic [ROWS_CFG_W-1:0] s;
		s = {1'b0, r} + {{(ROWS_CFG_W-1){1'b0}}, 1'b1};
		return (s >= n) ? '0 : s[ROW_W-1:0];
	endfunction

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	// A row count of zero acts as one, and a count above the matrix acts as the matrix.
	always_comb begin
		eff_rows = rows_q;
		if (rows_q == '0) begin
			eff_rows = {{(ROWS_CFG_W-1){1'b0}}, 1'b1};
		end else if (rows_q > ROWS_CFG_W'(MAX_ROWS)) begin
			eff_rows = ROWS_CFG_W'(MAX_ROWS);
		end
	end

	// Row select decode of a scan word.
	assign low     = key_word[LOW_W-1:0];
	assign one_hot = (low != '0) && ((low & (low - {{(LOW_W-1){1'b0}}, 1'b1})) == '0);
	always_comb begin
		row_enc = '0;
		for (int i = 0; i < LOW_W; i++) begin
			if (low[i]) begin
				row_enc = ROW_W'(i);
			end
		end
	end
	assign bad_row   = !one_hot || ({1'b0, row_enc} >= eff_rows);
	assign first_row = next_row(prev_q, eff_rows);

	// Idle tick: the counter saturates, and a timeout releases every held key.
	assign tick_next    = (idle_q == '1) ? idle_q : idle_q + {{(TMO_W-1){1'b0}}, 1'b1};
	assign tick_release = (held_q != '0) && (tick_next > timeout_q);

	// The row under the sweep is compared against what it should now hold.
	// Skipped rows and every row of a release go to all zeros.
	assign old_cols = map_q[cur_row_q[RIDX_W-1:0]];
	assign new_cols = (!rel_all_q && (cur_row_q == tgt_row_q)) ? tgt_cols_q : '0;
	assign sweep_last = rel_all_q ? (cur_row_q == LAST_ROW) : (cur_row_q == tgt_row_q);

	kmet_diff_unit #(
		.MAX_COLS (MAX_COLS)
	) u_diff (
		.old_cols  (old_cols),
		.new_cols  (new_cols),
		.held      (held_q),
		.found     (d_found),
		.col       (d_col),
		.press     (d_press),
		.upd_cols  (d_upd),
		.held_next (d_held)
	);

	// A bad row reports straight from the accept cycle; the buffer is empty in idle.
	always_comb begin
		buf_ctl.push = 1'b0;
		buf_ctl.fin  = (state_q == ST_FLUSH);
		evt.kind     = d_press ? EV_PRESS : EV_RELEASE;
		evt.row      = cur_row_q;
		evt.col      = d_col;
		evt.count    = d_held;
		if (state_q == ST_IDLE) begin
			buf_ctl.push = accept && (command == CMD_SCAN) && bad_row;
			evt.kind     = EV_BADROW;
			evt.row      = '0;
			evt.col      = '0;
			evt.count    = held_q;
		end else if (state_q == ST_SWEEP) begin
			buf_ctl.push = d_found;
		end
	end

	kmet_evt_buf u_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (buf_ctl),
		.evt           (evt),
		.sts           (buf_sts),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.event_kind    (event_kind),
		.key_row       (key_row),
		.key_col       (key_col),
		.pressed_count (pressed_count),
		.last_event    (last_event)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q    <= ROWS_RST;
			timeout_q <= TMO_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROWS:    rows_q    <= cfg_data[ROWS_CFG_W-1:0];
				CFG_TIMEOUT: timeout_q <= cfg_data[TMO_W-1:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			prev_q    <= '0;
			held_q    <= '0;
			idle_q    <= '0;
			cur_row_q <= '0;
			tgt_row_q <= '0;
			tgt_cols_q <= '0;
			rel_all_q <= 1'b0;
			for (int r = 0; r < MAX_ROWS; r++) begin
				map_q[r] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (command)
							CMD_SCAN: begin
								idle_q <= '0;
								if (bad_row) begin
									state_q <= ST_FLUSH;
								end else begin
									prev_q     <= row_enc;
									tgt_row_q  <= row_enc;
									tgt_cols_q <= key_word[LOW_W +: MAX_COLS];
									cur_row_q  <= first_row;
									rel_all_q  <= 1'b0;
									state_q    <= ST_SWEEP;
								end
							end
							CMD_TICK: begin
								idle_q <= tick_next;
								if (tick_release) begin
									cur_row_q <= '0;
									rel_all_q <= 1'b1;
									state_q   <= ST_SWEEP;
								end
							end
							CMD_ERROR: begin
								idle_q    <= '0;
								cur_row_q <= '0;
								rel_all_q <= 1'b1;
								state_q   <= ST_SWEEP;
							end
							default: ;
						endcase
					end
				end
				ST_SWEEP: begin
					if (d_found) begin
						if (buf_sts.room) begin
							map_q[cur_row_q[RIDX_W-1:0]] <= d_upd;
							held_q <= d_held;
						end
					end else if (sweep_last) begin
						state_q <= ST_FLUSH;
					end else if (rel_all_q) begin
						cur_row_q <= cur_row_q + {{(ROW_W-1){1'b0}}, 1'b1};
					end else begin
						cur_row_q <= next_row(cur_row_q, eff_rows);
					end
				end
				ST_FLUSH: begin
					if (buf_sts.room) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The held count never exceeds the number of keys in the matrix.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(MAX_ROWS * MAX_COLS))
		else $error("held key count exceeds matrix size");

	// Every event of an item has left the hold-back stage before the next item.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !buf_sts.pend_v)
		else $error("event left pending while idle");

	// After a full release no key is counted as held.
	a_release_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && rel_all_q) |-> (held_q == '0))
		else $error("keys still counted after release of all keys");

	// A bad row item goes straight to the flush with its single event pending.
	a_bad_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && accept && command == CMD_SCAN && bad_row) |=>
		(state_q == ST_FLUSH && buf_sts.pend_v))
		else $error("bad row item did not produce its event");

endmodule
